// ----- rtl/jnc_pkg.sv -----
// ----------------------------------------------------------------------------
// jnc_pkg: shared types and constants
// Opcode codes and pipeline stage records for the numeric conversion unit.
// ----------------------------------------------------------------------------
package jnc_pkg;

  typedef enum logic [3:0] {
    OP_I2L = 4'd0, OP_I2F = 4'd1, OP_I2D = 4'd2, OP_L2I = 4'd3,
    OP_L2F = 4'd4, OP_L2D = 4'd5, OP_F2I = 4'd6, OP_F2L = 4'd7,
    OP_F2D = 4'd8, OP_D2I = 4'd9, OP_D2L = 4'd10, OP_D2F = 4'd11,
    OP_I2B = 4'd12, OP_I2C = 4'd13, OP_I2S = 4'd14, OP_NONE = 4'd15
  } op_t;

  // Output of stage 1: unpacked operand, ready for the shift stage.
  typedef struct packed {
    op_t         op;
    logic        neg;
    logic [63:0] mag;     // integer magnitude, or significant with hidden bit
    logic [6:0]  lz;      // leading zero count of mag (int sources)
    logic        special; // result already final
    logic [63:0] fixed;   // final result when special
    logic [12:0] e;       // signed unbiased exponent (float sources)
  } s1_t;

  // Output of stage 2: aligned value plus rounding info.
  typedef struct packed {
    op_t         op;
    logic        neg;
    logic        special;
    logic [63:0] fixed;
    logic [63:0] val;     // truncated/aligned value
    logic        rnd_up;  // round-to-nearest-even increment
    logic [11:0] bexp;    // biased exponent for float results
    logic        subn;    // float result is subnormal (d2f)
  } s2_t;

endpackage

// ----- rtl/jnc_unpack.sv -----
// ----------------------------------------------------------------------------
// jnc_unpack: stage 1
// Classifies the operand, forms magnitudes and leading-zero counts, and
// resolves the trivial conversions directly.
// ----------------------------------------------------------------------------
module jnc_unpack import jnc_pkg::*; (
  input  logic [3:0]  operation,
  input  logic [63:0] operand,
  output s1_t         s1
);

  logic [31:0] lo;
  logic        n32, n64;
  logic [63:0] mag64;
  logic [7:0]  fex;
  logic [22:0] ffr;
  logic [10:0] dex;
  logic [51:0] dfr;
  logic [63:0] fnan, dnan;
  logic [6:0]  lzc;
  logic        found;

  always_comb begin
    lo  = operand[31:0];
    n32 = lo[31];
    n64 = operand[63];
    fex = lo[30:23];
    ffr = lo[22:0];
    dex = operand[62:52];
    dfr = operand[51:0];
    s1  = '0;
    s1.op = op_t'(operation);
    mag64 = '0;
    case (s1.op)
      OP_I2F, OP_I2D: begin
        s1.neg = n32;
        mag64 = {32'd0, n32 ? (32'd0 - lo) : lo};
      end
      OP_L2F, OP_L2D: begin
        s1.neg = n64;
        mag64 = n64 ? (64'd0 - operand) : operand;
      end
      default: mag64 = '0;
    endcase
    lzc = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && mag64[i]) begin
        lzc = 7'(63 - i);
        found = 1'b1;
      end
    end
    s1.lz  = lzc;
    s1.mag = mag64;
    fnan = {lo[31], 11'h7ff, 1'b1, ffr[21:0], 29'd0};
    dnan = {32'd0, operand[63], 8'hff, 1'b1, dfr[50:29]};
    case (s1.op)
      OP_I2L: begin s1.special = 1'b1; s1.fixed = {{32{n32}}, lo}; end
      OP_L2I: begin s1.special = 1'b1; s1.fixed = {32'd0, lo}; end
      OP_I2B: begin s1.special = 1'b1; s1.fixed = {32'd0, {24{lo[7]}}, lo[7:0]}; end
      OP_I2C: begin s1.special = 1'b1; s1.fixed = {48'd0, lo[15:0]}; end
      OP_I2S: begin s1.special = 1'b1; s1.fixed = {32'd0, {16{lo[15]}}, lo[15:0]}; end
      OP_NONE: begin s1.special = 1'b1; s1.fixed = '0; end
      OP_I2F, OP_I2D, OP_L2F, OP_L2D: begin
        s1.special = (mag64 == 64'd0);
        s1.fixed = '0;
      end
      OP_F2I, OP_F2L, OP_F2D: begin
        s1.neg = lo[31];
        s1.e   = 13'(signed'({1'b0, fex})) - 13'sd127;
        s1.mag = {40'd0, 1'b1, ffr};
        if (fex == 8'hff) begin
          s1.special = 1'b1;
          if (s1.op == OP_F2D)
            s1.fixed = (ffr == 0) ? {lo[31], 11'h7ff, 52'd0} : fnan;
          else if (ffr != 0) s1.fixed = '0;
          else if (s1.op == OP_F2I)
            s1.fixed = {32'd0, lo[31], {31{~lo[31]}}};
          else s1.fixed = {lo[31], {63{~lo[31]}}};
        end else if (fex == 8'd0) begin
          if (s1.op == OP_F2D && ffr != 0) begin
            // Subnormal single: normalize through the int path.
            s1.mag = {41'd0, ffr};
            s1.lz  = 7'd0;
            found  = 1'b0;
            for (int i = 22; i >= 0; i--) begin
              if (!found && ffr[i]) begin
                s1.lz = 7'(63 - i);
                found = 1'b1;
              end
            end
          end else begin
            s1.special = 1'b1;
            s1.fixed = (s1.op == OP_F2D) ? {lo[31], 63'd0} : 64'd0;
          end
        end
      end
      OP_D2I, OP_D2L, OP_D2F: begin
        s1.neg = operand[63];
        s1.e   = 13'(signed'({2'b0, dex})) - 13'sd1023;
        s1.mag = {11'd0, 1'b1, dfr};
        if (dex == 11'h7ff) begin
          s1.special = 1'b1;
          if (s1.op == OP_D2F)
            s1.fixed = (dfr == 0) ? {32'd0, operand[63], 8'hff, 23'd0} : dnan;
          else if (dfr != 0) s1.fixed = '0;
          else if (s1.op == OP_D2I)
            s1.fixed = {32'd0, operand[63], {31{~operand[63]}}};
          else s1.fixed = {operand[63], {63{~operand[63]}}};
        end else if (dex == 11'd0) begin
          s1.special = 1'b1;
          s1.fixed = (s1.op == OP_D2F) ? {32'd0, operand[63], 31'd0} : 64'd0;
        end
      end
      default: s1.special = 1'b0;
    endcase
  end

endmodule

// ----- rtl/jnc_align.sv -----
// ----------------------------------------------------------------------------
// jnc_align: stage 2
// One barrel shift per item: normalizes integers, aligns floating
// significands for truncation, and extracts guard and sticky for rounding.
// ----------------------------------------------------------------------------
module jnc_align import jnc_pkg::*; (
  input  s1_t s1,
  output s2_t s2
);

  logic [127:0] wide;
  logic [63:0]  norm;
  logic         g, st;
  logic [6:0]   p;
  logic [12:0]  ee;
  logic [6:0]   sh;

  always_comb begin
    s2 = '0;
    s2.op = s1.op;
    s2.neg = s1.neg;
    s2.special = s1.special;
    s2.fixed = s1.fixed;
    norm = s1.mag << s1.lz;   // msb at bit 63
    p = 7'd63 - s1.lz;
    g = 1'b0;
    st = 1'b0;
    wide = '0;
    sh = '0;
    ee = s1.e;
    case (s1.op)
      OP_I2F, OP_L2F: begin
        s2.val  = {40'd0, norm[63:40]};
        g       = norm[39];
        st      = |norm[38:0];
        s2.bexp = 12'(p) + 12'd126;
      end
      OP_I2D, OP_L2D, OP_F2D: begin
        s2.val  = {11'd0, norm[63:11]};
        g       = norm[10];
        st      = |norm[9:0];
        s2.bexp = (s1.op == OP_F2D) ? 12'(p) + 12'd1022 - 12'd149 : 12'(p) + 12'd1022;
        if (s1.op == OP_F2D && s1.lz == 7'd64) begin
          // Normal single: exact widening.
          s2.val  = {11'd0, 1'b1, s1.mag[22:0], 29'd0};
          s2.bexp = 12'(ee + 13'sd1022);
        end
      end
      OP_F2I, OP_F2L, OP_D2I, OP_D2L: begin
        if (!s1.special) begin
          if ($signed(ee) < 0) begin
            s2.special = 1'b1; s2.fixed = '0;
          end else if (((s1.op == OP_F2I || s1.op == OP_D2I) && $signed(ee) >= 13'sd31) ||
                       $signed(ee) >= 13'sd63) begin
            s2.special = 1'b1;
            if (s1.op == OP_F2I || s1.op == OP_D2I)
              s2.fixed = {32'd0, s1.neg, {31{~s1.neg}}};
            else s2.fixed = {s1.neg, {63{~s1.neg}}};
          end else begin
            // Significand sits with its binary point below bit 52 or 23.
            wide = {64'd0, s1.mag} << ee[5:0];
            if (s1.op == OP_F2I || s1.op == OP_F2L) s2.val = wide[86:23];
            else s2.val = wide[115:52];
          end
        end
      end
      OP_D2F: begin
        if (!s1.special) begin
          if ($signed(ee) > 13'sd127) begin
            s2.special = 1'b1; s2.fixed = {32'd0, s1.neg, 8'hff, 23'd0};
          end else begin
            if ($signed(ee) >= -13'sd126) sh = 7'd29;
            else if ($signed(ee) < -13'sd157) begin
              s2.special = 1'b1; s2.fixed = {32'd0, s1.neg, 31'd0};
            end else sh = 7'(13'sd29 - 13'sd126 - ee);
            s2.subn = ($signed(ee) < -13'sd126);
            s2.bexp = 12'(ee + 13'sd126);
            wide = {s1.mag, 64'd0} >> sh;
            s2.val = wide[127:64];
            g  = wide[63];
            st = |wide[62:0];
          end
        end
      end
      default: s2.val = '0;
    endcase
    s2.rnd_up = g & (st | s2.val[0]);
  end

endmodule

// ----- rtl/jnc_pack.sv -----
// ----------------------------------------------------------------------------
// jnc_pack: stage 3
// Applies rounding and sign, and assembles the final result word.
// ----------------------------------------------------------------------------
module jnc_pack import jnc_pkg::*; (
  input  s2_t         s2,
  output logic [63:0] converted,
  output logic        is_wide
);

  logic [63:0] r;
  logic [63:0] neg_v;

  always_comb begin
    r = s2.val + {63'd0, s2.rnd_up};
    neg_v = 64'd0 - s2.val;
    is_wide = (s2.op == OP_I2L) || (s2.op == OP_I2D) || (s2.op == OP_L2D) ||
              (s2.op == OP_F2L) || (s2.op == OP_F2D) || (s2.op == OP_D2L);
    converted = '0;
    if (s2.special) converted = s2.fixed;
    else begin
      case (s2.op)
        OP_I2F, OP_L2F:
          converted = {32'd0, s2.neg, 31'({s2.bexp[7:0], 23'd0} + r[30:0])};
        OP_I2D, OP_L2D, OP_F2D:
          converted = {s2.neg, 63'({s2.bexp[10:0], 52'd0} + r[62:0])};
        OP_D2F:
          converted = s2.subn ? {32'd0, s2.neg, r[30:0]}
                              : {32'd0, s2.neg, 31'({s2.bexp[7:0], 23'd0} + r[30:0])};
        OP_F2I, OP_D2I:
          converted = {32'd0, s2.neg ? neg_v[31:0] : s2.val[31:0]};
        OP_F2L, OP_D2L:
          converted = s2.neg ? neg_v : s2.val;
        default: converted = '0;
      endcase
    end
  end

endmodule

// ----- rtl/jvm_numeric_conversion_unit.sv -----
// Registers: an input register, then the unpack, align and pack stages, each ending in
// a register; one item per cycle while out_tready does not stall the pipeline.
// Stalls propagate back through the stage valid bits; a bubble is filled.
// Reset (rst_n low, synchronous) clears all stage valid bits.
// ----------------------------------------------------------------------------
// jvm_numeric_conversion_unit: JVM primitive cast pipeline
// Unpack, align and pack stages with valid bits and per-stage advance enables.
// ----------------------------------------------------------------------------
module jvm_numeric_conversion_unit import jnc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [3:0] operation, [67:4] operand, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [63:0] converted, [64] is_wide, zero pad
);

  s1_t  s1_c, s1_r;
  s2_t  s2_c, s2_r;
  logic [63:0] conv_c;
  logic        wide_c;
  logic [3:0]  op_r;
  logic [63:0] opd_r;
  logic v0_r, v1_r, v2_r, v3_r;
  logic [64:0] res_r;
  logic adv3, adv2, adv1, adv0;

  assign adv3 = !v3_r || out_tready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign adv0 = !v0_r || adv1;
  assign in_tready = adv0;

  jnc_unpack u_unpack (.operation(op_r), .operand(opd_r), .s1(s1_c));
  jnc_align  u_align  (.s1(s1_r), .s2(s2_c));
  jnc_pack   u_pack   (.s2(s2_r), .converted(conv_c), .is_wide(wide_c));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else begin
      if (adv0) v0_r <= in_tvalid;
      if (adv1) v1_r <= v0_r;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin op_r <= in_tdata[3:0]; opd_r <= in_tdata[67:4]; end
    if (adv1) s1_r <= s1_c;
    if (adv2) s2_r <= s2_c;
    if (adv3) res_r <= {wide_c, conv_c};
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {7'd0, res_r};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_tready |=> v3_r && $stable(res_r)) else $error("result lost");
  a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !res_r[64] |-> res_r[63:32] == 32'd0) else $error("upper half set");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !v3_r |-> in_tready) else $error("bubble not filled");

endmodule

// ----- dv/jvm_numeric_conversion_unit_chk.sv -----
// ----------------------------------------------------------------------------
// jvm_numeric_conversion_unit_chk: result checker for the conversion unit
// Watches both stream channels, computes the expected cast of every input
// transfer and compares each output transfer against the oldest one pending.
// ----------------------------------------------------------------------------
module jvm_numeric_conversion_unit_chk import jnc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  typedef struct packed {
    logic [63:0] converted;
    logic        is_wide;
  } cast_t;

  cast_t pending_casts[$];

  function automatic int unsigned top_bit(logic [63:0] v);
    int unsigned p;
    p = 0;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    return p;
  endfunction

  // Round an integer magnitude to nearest even; frac_bits selects float or double.
  function automatic logic [63:0] int_to_real(logic neg, logic [63:0] mag,
                                              int unsigned frac_bits, int unsigned bias,
                                              int unsigned sign_pos);
    int unsigned p, sh;
    logic [63:0] keep, rem, half;
    if (mag == 0) return 64'd0;
    p = top_bit(mag);
    if (p > frac_bits) begin
      sh = p - frac_bits;
      rem = mag & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      keep = mag >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
    end else begin
      keep = mag << (frac_bits - p);
    end
    // The hidden bit sits in keep, so a rounding carry bumps the exponent.
    return (64'(neg) << sign_pos) + (64'(p + bias - 1) << frac_bits) + keep;
  endfunction

  function automatic logic [63:0] real_to_int(logic [63:0] bits, int unsigned frac_bits,
                                              int unsigned exp_bits, int bias,
                                              int unsigned w);
    logic neg;
    logic [63:0] ex, frac, wmask, maxv, minv, sig, mag;
    int e;
    neg = bits[frac_bits + exp_bits];
    ex = (bits >> frac_bits) & ((64'd1 << exp_bits) - 1);
    frac = bits & ((64'd1 << frac_bits) - 1);
    wmask = (w >= 64) ? '1 : ((64'd1 << w) - 1);
    maxv = (64'd1 << (w - 1)) - 1;
    minv = 64'd1 << (w - 1);
    if (ex == (64'd1 << exp_bits) - 1) return (frac != 0) ? 64'd0 : (neg ? minv : maxv);
    if (ex == 0) return 64'd0;
    e = int'(ex) - bias;
    if (e < 0) return 64'd0;
    if (e >= int'(w) - 1) return neg ? minv : maxv;
    sig = (64'd1 << frac_bits) | frac;
    if (e >= int'(frac_bits)) mag = sig << (e - frac_bits);
    else mag = sig >> (frac_bits - e);
    return (neg ? (64'd0 - mag) : mag) & wmask;
  endfunction

  function automatic logic [63:0] widen_float(logic [31:0] f);
    logic [63:0] s, frac;
    logic [7:0] ex;
    int unsigned p;
    s = 64'(f[31]) << 63;
    ex = f[30:23];
    frac = 64'(f[22:0]);
    if (ex == 8'hFF) begin
      if (frac == 0) return s | (64'h7FF << 52);
      return s | (64'h7FF << 52) | ((frac | 64'h400000) << 29);
    end
    if (ex == 0) begin
      if (frac == 0) return s;
      p = top_bit(frac);
      return s | (64'(p + 1023 - 149) << 52) | ((frac << (52 - p)) & ((64'd1 << 52) - 1));
    end
    return s | (64'(ex - 127 + 1023) << 52) | (frac << 29);
  endfunction

  function automatic logic [31:0] narrow_double(logic [63:0] d);
    logic [31:0] s;
    logic [63:0] frac, sig, keep, rem, half;
    int e, sh;
    s = {d[63], 31'd0};
    frac = d & ((64'd1 << 52) - 1);
    if (d[62:52] == 11'h7FF) begin
      if (frac == 0) return s | 32'h7F800000;
      return s | 32'h7F800000 | 32'(frac >> 29) | 32'h400000;
    end
    if (d[62:52] == 0) return s;
    e = int'(d[62:52]) - 1023;
    if (e > 127) return s | 32'h7F800000;
    sig = (64'd1 << 52) | frac;
    if (e >= -126) sh = 29;
    else begin
      sh = 29 + (-126 - e);
      if (sh > 60) return s;
    end
    keep = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && keep[0])) keep++;
    if (e >= -126) return s | 32'((64'(e + 126) << 23) + keep);
    return s | 32'(keep);
  endfunction

  function automatic cast_t convert(op_t op, logic [63:0] x);
    cast_t r;
    logic [63:0] lo;
    logic n32, n64;
    lo = {32'd0, x[31:0]};
    n32 = x[31];
    n64 = x[63];
    r = '0;
    case (op)
      OP_I2L: begin r.converted = {{32{n32}}, x[31:0]}; r.is_wide = 1'b1; end
      OP_I2F: r.converted = int_to_real(n32, n32 ? ((64'd0 - lo) & 64'hFFFF_FFFF) : lo,
                                        23, 127, 31);
      OP_I2D: begin
        r.converted = int_to_real(n32, n32 ? ((64'd0 - lo) & 64'hFFFF_FFFF) : lo,
                                  52, 1023, 63);
        r.is_wide = 1'b1;
      end
      OP_L2I: r.converted = lo;
      OP_L2F: r.converted = int_to_real(n64, n64 ? (64'd0 - x) : x, 23, 127, 31);
      OP_L2D: begin
        r.converted = int_to_real(n64, n64 ? (64'd0 - x) : x, 52, 1023, 63);
        r.is_wide = 1'b1;
      end
      OP_F2I: r.converted = real_to_int(lo, 23, 8, 127, 32);
      OP_F2L: begin r.converted = real_to_int(lo, 23, 8, 127, 64); r.is_wide = 1'b1; end
      OP_F2D: begin r.converted = widen_float(x[31:0]); r.is_wide = 1'b1; end
      OP_D2I: r.converted = real_to_int(x, 52, 11, 1023, 32);
      OP_D2L: begin r.converted = real_to_int(x, 52, 11, 1023, 64); r.is_wide = 1'b1; end
      OP_D2F: r.converted = {32'd0, narrow_double(x)};
      OP_I2B: r.converted = {32'd0, {24{x[7]}}, x[7:0]};
      OP_I2C: r.converted = {48'd0, x[15:0]};
      OP_I2S: r.converted = {32'd0, {16{x[15]}}, x[15:0]};
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending_count = pending_casts.size();

  always @(posedge clk) begin
    cast_t want;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
      pending_casts.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (pending_casts.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_casts.pop_front();
          if (out_tdata[63:0] !== want.converted || out_tdata[64] !== want.is_wide ||
              out_tdata[71:65] !== 7'd0) begin
            $display("%0t: mismatch: expected converted %h wide %b, got converted %h wide %b pad %h",
                     $time, want.converted, want.is_wide, out_tdata[63:0], out_tdata[64],
                     out_tdata[71:65]);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_casts.push_back(convert(op_t'(in_tdata[3:0]), in_tdata[67:4]));
    end
  end

endmodule

// ----- dv/jvm_numeric_conversion_unit_tb.sv -----
// ----------------------------------------------------------------------------
// jvm_numeric_conversion_unit_tb: stream testbench for the conversion unit
// Drives directed edge operands and random shaped values for every cast
// under several idle and stall mixes; a separate checker predicts results.
// ----------------------------------------------------------------------------
module jvm_numeric_conversion_unit_tb import jnc_pkg::*;;

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  int          idle_cycles;

  jvm_numeric_conversion_unit dut (.*);

  jvm_numeric_conversion_unit_chk checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off while the sender keeps going.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("jvm_numeric_conversion_unit_tb failed");
      $finish;
    end
  end

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // Operands shaped to hit exponents near the interesting boundaries.
  function automatic logic [63:0] shaped_operand(op_t op);
    logic [63:0] x;
    x = random_word();
    case ($urandom_range(3))
      0: ;
      1: case (op)
        OP_F2I, OP_F2L, OP_F2D: x[30:23] = 8'(127 + $urandom_range(70) - 35);
        OP_D2I, OP_D2L, OP_D2F: x[62:52] = 11'(1023 + $urandom_range(340) - 170);
        default: x = x >> $urandom_range(63);
      endcase
      2: case (op)
        OP_F2I, OP_F2L, OP_F2D: x[30:23] = ($urandom_range(1)) ? 8'hFF : 8'h00;
        OP_D2I, OP_D2L, OP_D2F: x[62:52] = ($urandom_range(1)) ? 11'h7FF : 11'h000;
        default: x = -(x >> $urandom_range(63));
      endcase
      default: if (op == OP_D2F) begin
        x[62:52] = 11'(1023 - 126 - $urandom_range(30));
        x[28:0] = ($urandom_range(1)) ? 29'h1000_0000 : x[28:0];
      end else begin
        x = x & ~((64'd1 << $urandom_range(40)) - 1);
      end
    endcase
    return x;
  endfunction

  task automatic send(logic [3:0] op, logic [63:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, x, op};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] edges[] = '{64'd0, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000,
                             64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                             64'h7FF0_0000_0000_0001, 64'h0000_0000_7F80_0001,
                             64'h0000_0000_0000_0001, 64'h47EF_FFFF_F000_0000};
    op_t op;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every opcode including the unused one, on boundary operands.
    foreach (edges[i]) send(i[3:0], edges[i]);
    for (int k = 0; k < 16; k++) send(k[3:0], edges[k % 9] ^ 64'hFFFF_FFFF_0000_0000);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 71 : 32) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 71 : 32) : 0;
      if (phase == 0) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (60) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 350; n++) begin
        op = op_t'($urandom_range(14));
        send(($urandom_range(40) == 0) ? OP_NONE : op, shaped_operand(op));
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered all fifteen casts plus the unused opcode, %0d results checked,",
             result_count);
    $display("with edge operands, NaN/infinity/subnormal cases and four idle/stall mixes.");
    if (fail_count == 0 && pending_count == 0)
      $display("jvm_numeric_conversion_unit_tb passed");
    else
      $display("jvm_numeric_conversion_unit_tb failed");
    $finish;
  end

endmodule
